FILE: design/tbs_pkg.sv
// Shared types and codes of the token bucket shaper.
`default_nettype none
package tbs_pkg;

  // One waiting packet as held in the queue memory.
  typedef struct packed {
    logic [15:0] num;
    logic [15:0] serv;
    logic [15:0] need;
  } tbs_entry_t;

  // Result status codes.
  localparam logic [2:0] ST_QUEUED    = 3'd0;
  localparam logic [2:0] ST_FORWARDED = 3'd1;
  localparam logic [2:0] ST_DROP_BIG  = 3'd2;
  localparam logic [2:0] ST_DROP_FULL = 3'd3;
  localparam logic [2:0] ST_TOK_KEPT  = 3'd4;
  localparam logic [2:0] ST_TOK_DROP  = 3'd5;

  // Command codes.
  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // Register indexes.
  localparam logic REG_BUCKET_DEPTH = 1'b0;

  localparam logic [15:0] BUCKET_DEPTH_RESET = 16'd10;

endpackage
`default_nettype wire

FILE: design/tbs_mem.sv
// Queue memory: one write port, one read port with registered read data.
`default_nettype none
module tbs_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire tbs_pkg::tbs_entry_t wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output tbs_pkg::tbs_entry_t    rdata
);
  import tbs_pkg::*;

  tbs_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: design/tbs_apb.sv
// Configuration register port: holds the bucket depth.
`default_nettype none
module tbs_apb (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [15:0]      bucket_depth
);
  import tbs_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  // decode on the word index; byte lanes below it are ignored
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_BUCKET_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_depth <= BUCKET_DEPTH_RESET;
    end else if (wr_en) begin
      bucket_depth <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_BUCKET_DEPTH) begin
      prdata = {16'd0, bucket_depth};
    end else begin
      prdata = 32'd0;
    end
  end

endmodule
`default_nettype wire

FILE: design/token_bucket_shaper.sv
// Token bucket shaper top level: control, queue state and result register.
// The accept edge writes the tail and reads the head entry into the registered read data;
// the result register loads as the evaluate state ends. No new beat is taken until then;
// the evaluate cycle holds while a previous result is not yet taken.
// Reset (rst, synchronous, input held off): level, pointers, fill, sequence and control clear,
// depth back to 10; queue contents are not cleared and need no clearing pass.
`default_nettype none
module token_bucket_shaper #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input beats
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] tokens_needed, [31:16] service_time
  input  wire logic [0:0]  s_tuser,   // [0] command
  // result beats
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [15:0] packet_number, [31:16] packet_service_time,
                                      // [47:32] bucket_level, [54:48] queue_count, [55] zero
  output logic [2:0]       m_tuser,   // [2:0] status
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tbs_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EVAL = 1'b1;

  logic [15:0]   bucket_depth;
  logic          state;
  logic [15:0]   level;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [FW-1:0] fill;
  logic [15:0]   seq;

  // latched beat
  logic          cmd;
  logic          too_big;
  logic          enq;
  logic          fwd;
  tbs_entry_t    item;

  tbs_entry_t    rd_entry;
  tbs_entry_t    head_entry;
  tbs_entry_t    wr_entry;

  logic          accept;
  logic          done;
  logic [15:0]   seq_inc;
  logic          in_too_big;
  logic          in_enq;

  logic [15:0]   level_next;
  logic [AW-1:0] head_next;
  logic [FW-1:0] fill_next;
  logic [15:0]   level_tmp;
  logic [FW-1:0] fill_tmp;
  logic          tick_kept;
  logic          release_ok;
  logic [2:0]    res_status;
  logic [15:0]   res_num;
  logic [15:0]   res_serv;

  tbs_apb u_apb (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .bucket_depth (bucket_depth)
  );

  // Accept side: numbering, drop checks and the tail write all happen on the accept edge.
  // Hold off input while reset is applied.
  assign s_tready   = (state == S_IDLE) && !rst;
  assign accept     = s_tvalid && s_tready;
  assign seq_inc    = seq + 16'd1;
  assign in_too_big = (s_tdata[15:0] > bucket_depth);
  assign in_enq     = (s_tuser[0] == CMD_ARRIVAL) && !in_too_big && (fill != FULL_FILL);

  assign wr_entry.num  = seq_inc;
  assign wr_entry.serv = s_tdata[31:16];
  assign wr_entry.need = s_tdata[15:0];

  tbs_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (accept && in_enq),
    .waddr (tail),
    .wdata (wr_entry),
    .re    (accept),
    .raddr (head),
    .rdata (rd_entry)
  );

  // With an empty queue the head slot is the one written on this edge: forward the beat.
  assign head_entry = fwd ? item : rd_entry;

  // Evaluate side: bucket update, head release and result.
  always_comb begin
    tick_kept = (cmd == CMD_TICK) && (level < bucket_depth);
    level_tmp = tick_kept ? (level + 16'd1) : level;
    fill_tmp  = fill + FW'(enq);
    release_ok = (fill_tmp != '0) && (head_entry.need <= level_tmp) &&
                 (enq || tick_kept);

    level_next = level_tmp;
    head_next  = head;
    fill_next  = fill_tmp;
    res_serv   = 16'd0;
    res_num    = (cmd == CMD_ARRIVAL) ? item.num : 16'd0;

    if (release_ok) begin
      level_next = level_tmp - head_entry.need;
      head_next  = (head == LAST_PTR) ? '0 : (head + AW'(1));
      fill_next  = fill_tmp - FW'(1);
      res_num    = head_entry.num;
      res_serv   = head_entry.serv;
    end

    if (cmd == CMD_ARRIVAL) begin
      if (too_big) begin
        res_status = ST_DROP_BIG;
      end else if (!enq) begin
        res_status = ST_DROP_FULL;
      end else if (release_ok) begin
        res_status = ST_FORWARDED;
      end else begin
        res_status = ST_QUEUED;
      end
    end else begin
      if (!tick_kept) begin
        res_status = ST_TOK_DROP;
      end else if (release_ok) begin
        res_status = ST_FORWARDED;
      end else begin
        res_status = ST_TOK_KEPT;
      end
    end
  end

  // Hold the evaluate cycle until the result register is free or being emptied.
  assign done = (state == S_EVAL) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      level    <= 16'd0;
      head     <= '0;
      tail     <= '0;
      fill     <= '0;
      seq      <= 16'd0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EVAL;
            if (s_tuser[0] == CMD_ARRIVAL) begin
              seq <= seq_inc;
            end
            if (in_enq) begin
              tail <= (tail == LAST_PTR) ? '0 : (tail + AW'(1));
            end
          end
        end
        S_EVAL: begin
          if (done) begin
            state <= S_IDLE;
            level <= level_next;
            head  <= head_next;
            fill  <= fill_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Beat and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd     <= s_tuser[0];
      too_big <= in_too_big;
      enq     <= in_enq;
      fwd     <= (fill == '0);
      item    <= wr_entry;
    end
    if (done) begin
      m_tuser <= res_status;
      m_tdata <= {1'b0, 7'(fill_next), level_next, res_serv, res_num};
    end
  end

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking bench for the token bucket shaper: directed table and random phases.
`default_nettype none
module testbench;
  import tbs_pkg::*;

  localparam int QDEPTH = 64;
  // Register 0 sits at byte address 0; the next slot up is unmapped.
  localparam logic [2:0] ADDR_BUCKET_DEPTH = {2'b00, REG_BUCKET_DEPTH} << 2;
  localparam logic [2:0] ADDR_SPARE        = 3'd4;
  localparam int NUM_ROWS   = 31;
  localparam int NUM_PHASES = 9;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] num;
    logic [15:0] serv;
    logic [15:0] level;
    logic [6:0]  count;
  } shaper_result_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  // One row of the directed table; for ROW_CFG the need column carries the write data.
  typedef struct packed {
    row_kind_t      kind;
    logic [2:0]     addr;
    logic           cmd;
    logic [15:0]    need;
    logic [15:0]    serv;
    logic           typed;
    shaper_result_t res;
  } dir_row_t;

  localparam shaper_result_t NONE = '0;

  localparam dir_row_t DIRECTED [NUM_ROWS] = '{
    // first packet needs nothing: forwarded at once
    '{ROW_BEAT, 3'd0, CMD_ARRIVAL, 16'd0, 16'hFFFF, 1'b1,
      '{ST_FORWARDED, 16'd1, 16'hFFFF, 16'd0, 7'd0}},
    // one token over the depth, then the largest need
    '{ROW_BEAT, 3'd0, CMD_ARRIVAL, 16'd11, 16'd5, 1'b1,
      '{ST_DROP_BIG, 16'd2, 16'd0, 16'd0, 7'd0}},
    '{ROW_BEAT, 3'd0, CMD_ARRIVAL, 16'hFFFF, 16'hFFFF, 1'b1,
      '{ST_DROP_BIG, 16'd3, 16'd0, 16'd0, 7'd0}},
    '{ROW_BEAT, 3'd0, CMD_ARRIVAL, 16'd3, 16'h1234, 1'b1,
      '{ST_QUEUED, 16'd4, 16'd0, 16'd0, 7'd1}},
    '{ROW_BEAT, 3'd0, CMD_TICK, 16'hFFFF, 16'hFFFF, 1'b1,
      '{ST_TOK_KEPT, 16'd0, 16'd0, 16'd1, 7'd1}},
    '{ROW_BEAT, 3'd0, CMD_TICK, 16'd0, 16'd0, 1'b0, NONE},
    // third token covers the head
    '{ROW_BEAT, 3'd0, CMD_TICK, 16'd0, 16'd0, 1'b1,
      '{ST_FORWARDED, 16'd4, 16'h1234, 16'd0, 7'd0}},
    '{ROW_BEAT, 3'd0, CMD_TICK, 16'd0, 16'd0, 1'b0, NONE},
    '{ROW_BEAT, 3'd0, CMD_TICK, 16'd0, 16'd0, 1'b0, NONE},
    '{ROW_BEAT, 3'd0, CMD_TICK, 16'd0, 16'd0, 1'b0, NONE},
    // need equal to the depth waits at the head
    '{ROW_BEAT, 3'd0, CMD_ARRIVAL, 16'd10, 16'hBEEF, 1'b0, NONE},
    // depth below the level: ticks drop, level is kept
    '{ROW_CFG, ADDR_BUCKET_DEPTH, CMD_ARRIVAL, 16'd1, 16'd0, 1'b0, NONE},
    '{ROW_BEAT, 3'd0, CMD_TICK, 16'd0, 16'd0, 1'b1,
      '{ST_TOK_DROP, 16'd0, 16'd0, 16'd3, 7'd1}},
    '{ROW_BEAT, 3'd0, CMD_ARRIVAL, 16'd1, 16'd7, 1'b0, NONE},
    '{ROW_BEAT, 3'd0, CMD_ARRIVAL, 16'd2, 16'd0, 1'b0, NONE},
    // zero depth: only zero-need packets get in
    '{ROW_CFG, ADDR_BUCKET_DEPTH, CMD_ARRIVAL, 16'd0, 16'd0, 1'b0, NONE},
    '{ROW_BEAT, 3'd0, CMD_TICK, 16'd0, 16'd0, 1'b0, NONE},
    '{ROW_BEAT, 3'd0, CMD_ARRIVAL, 16'd0, 16'd9, 1'b0, NONE},
    '{ROW_BEAT, 3'd0, CMD_ARRIVAL, 16'd1, 16'd0, 1'b0, NONE},
    // unmapped register: no effect
    '{ROW_CFG, ADDR_SPARE, CMD_ARRIVAL, 16'd100, 16'd0, 1'b0, NONE},
    '{ROW_BEAT, 3'd0, CMD_TICK, 16'd0, 16'd0, 1'b0, NONE},
    // widest depth, then refill until the blocked head and the rest drain
    '{ROW_CFG, ADDR_BUCKET_DEPTH, CMD_ARRIVAL, 16'hFFFF, 16'd0, 1'b0, NONE},
    '{ROW_BEAT, 3'd0, CMD_TICK, 16'd0, 16'd0, 1'b0, NONE},
    '{ROW_BEAT, 3'd0, CMD_TICK, 16'd0, 16'd0, 1'b0, NONE},
    '{ROW_BEAT, 3'd0, CMD_TICK, 16'd0, 16'd0, 1'b0, NONE},
    '{ROW_BEAT, 3'd0, CMD_TICK, 16'd0, 16'd0, 1'b0, NONE},
    '{ROW_BEAT, 3'd0, CMD_TICK, 16'd0, 16'd0, 1'b0, NONE},
    '{ROW_BEAT, 3'd0, CMD_TICK, 16'd0, 16'd0, 1'b0, NONE},
    '{ROW_BEAT, 3'd0, CMD_TICK, 16'd0, 16'd0, 1'b0, NONE},
    '{ROW_BEAT, 3'd0, CMD_TICK, 16'd0, 16'd0, 1'b0, NONE},
    '{ROW_BEAT, 3'd0, CMD_TICK, 16'd0, 16'd0, 1'b0, NONE}
  };

  // Random phases: depth, chance of a tick in percent, item count.
  localparam int PHASE_DEPTH [NUM_PHASES] = '{10, 16, 65535, 40, 3, 1, 0, 12, 65535};
  localparam int PHASE_TICK  [NUM_PHASES] = '{50, 15, 70, 90, 50, 40, 30, 60, 95};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{200, 250, 200, 200, 150, 150, 100, 200, 150};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire logic   s_tready;
  logic [31:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  wire logic   m_tvalid;
  logic        m_tready = 1'b0;
  wire logic [55:0] m_tdata;
  wire logic [2:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire logic [31:0] prdata;
  wire logic   pready;

  token_bucket_shaper #(.QUEUE_DEPTH(QDEPTH)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow state of the shaper.
  logic [15:0]    depth_shadow = BUCKET_DEPTH_RESET;
  logic [15:0]    bucket_tokens = '0;
  logic [15:0]    pkt_seq = '0;
  tbs_entry_t     waiting_pkts [$];
  shaper_result_t expected_results [$];

  int tx_idle = 10;
  int rx_idle = 10;
  int mismatches = 0;

  // Release the head if the bucket covers it; one release at most.
  function automatic void release_head(inout shaper_result_t r);
    tbs_entry_t head;
    if (waiting_pkts.size() != 0 && waiting_pkts[0].need <= bucket_tokens) begin
      head = waiting_pkts.pop_front();
      bucket_tokens = bucket_tokens - head.need;
      r.status = ST_FORWARDED;
      r.num = head.num;
      r.serv = head.serv;
    end
  endfunction

  function automatic shaper_result_t predict_result(logic cmd, logic [15:0] need,
                                                    logic [15:0] serv);
    shaper_result_t r;
    r = '0;
    if (cmd == CMD_ARRIVAL) begin
      // every arrival takes a number, dropped ones too
      pkt_seq = pkt_seq + 16'd1;
      r.num = pkt_seq;
      if (need > depth_shadow) begin
        r.status = ST_DROP_BIG;
      end else if (waiting_pkts.size() >= QDEPTH) begin
        r.status = ST_DROP_FULL;
      end else begin
        waiting_pkts.push_back('{num: pkt_seq, serv: serv, need: need});
        r.status = ST_QUEUED;
        release_head(r);
      end
    end else if (bucket_tokens >= depth_shadow) begin
      r.status = ST_TOK_DROP;
    end else begin
      bucket_tokens = bucket_tokens + 16'd1;
      r.status = ST_TOK_KEPT;
      release_head(r);
    end
    r.level = bucket_tokens;
    r.count = 7'(waiting_pkts.size());
    return r;
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Offer one beat after a random gap and hold it until taken.
  task automatic send_beat(logic cmd, logic [15:0] need, logic [15:0] serv,
                           logic typed, shaper_result_t res);
    int gap;
    shaper_result_t pred;
    gap = $urandom_range(0, tx_idle);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {serv, need};
    do @(posedge clk); while (s_tready !== 1'b1);
    pred = predict_result(cmd, need, serv);
    expected_results.push_back(typed ? res : pred);
  endtask

  // Drop valid, wait for every result, then write one register.
  task automatic settle_and_write(logic [2:0] addr, logic [31:0] data);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_BUCKET_DEPTH) depth_shadow = data[15:0];
  endtask

  // Result side: random stalls, compare every beat with the oldest expectation.
  initial begin
    int gap;
    shaper_result_t want, got;
    wait (rst == 1'b0);
    forever begin
      gap = $urandom_range(0, rx_idle);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      got = '{m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[54:48]};
      if (expected_results.size() == 0) begin
        $display("%0t: no result expected, got status %0d number %0d", $time,
                 got.status, got.num);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, got.status);
        check_field("packet_number", want.num, got.num);
        check_field("packet_service_time", want.serv, got.serv);
        check_field("bucket_level", want.level, got.level);
        check_field("queue_count", want.count, got.count);
      end
    end
  end

  initial begin
    int r;
    int cap;
    logic        cmd;
    logic [15:0] need;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        settle_and_write(DIRECTED[i].addr, {16'd0, DIRECTED[i].need});
      end else begin
        send_beat(DIRECTED[i].cmd, DIRECTED[i].need, DIRECTED[i].serv,
                  DIRECTED[i].typed, DIRECTED[i].res);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_and_write(ADDR_BUCKET_DEPTH, {16'($urandom), 16'(PHASE_DEPTH[p])});
      // keep needs small so heads can be covered; a share overshoots the depth
      cap = (PHASE_DEPTH[p] < 16) ? PHASE_DEPTH[p] : 16;
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        r = $urandom_range(0, 99);
        cmd = ($urandom_range(0, 99) < PHASE_TICK[p]) ? CMD_TICK : CMD_ARRIVAL;
        if (cmd == CMD_TICK) begin
          need = 16'($urandom);
        end else if (r < 12 && PHASE_DEPTH[p] < 65535) begin
          need = 16'($urandom_range(PHASE_DEPTH[p] + 1, 65535));
        end else begin
          need = 16'($urandom_range(0, cap));
        end
        send_beat(cmd, need, 16'($urandom), 1'b0, NONE);
      end
    end

    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
design/tbs_pkg.sv
design/tbs_mem.sv
design/tbs_apb.sv
design/token_bucket_shaper.sv
test/testbench.sv
